>>> rtl/core/point_in_shape_test_defines.svh
// assertion macros for the point-in-shape test block
`ifndef POINT_IN_SHAPE_TEST_DEFINES_SVH
`define POINT_IN_SHAPE_TEST_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define PIS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`define PIS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define PIS_ASSERT_IMP(lbl, ante, cons, msg)
`define PIS_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

>>> rtl/core/pis_pkg.sv
// types and constants of the point-in-shape test block
package pis_pkg;

  localparam int COORD_W     = 32;
  localparam int INDEX_W     = 5;
  localparam int COUNT_W     = 6;
  localparam int RADIUS_W    = 31;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 32;

  localparam logic [COUNT_W-1:0]  COUNT_RESET  = COUNT_W'(4);
  localparam logic [RADIUS_W-1:0] RADIUS_RESET = RADIUS_W'(65536);

  typedef enum logic {
    OP_QUERY = 1'b0,
    OP_LOAD  = 1'b1
  } op_e;

  typedef enum logic {
    MODE_POLYGON = 1'b0,
    MODE_CIRCLE  = 1'b1
  } shape_mode_e;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_SHAPE_MODE    = 3'd0,
    CFG_VERTEX_COUNT  = 3'd1,
    CFG_CENTER_X      = 3'd2,
    CFG_CENTER_Y      = 3'd3,
    CFG_CIRCLE_RADIUS = 3'd4
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN
  } state_e;

  // tag that travels with each slot down the pipeline
  typedef struct packed {
    logic valid;
    logic first;   // vertex 0 arrives, keep it for the closing edge
    logic edge_v;  // an edge is tested in this slot
    logic close;   // closing edge, second end is vertex 0
    logic last;    // final slot of the query
    logic circle;  // circle distance test
  } slot_t;

endpackage

>>> rtl/core/point_in_shape_test.sv
// point-in-shape test: polygon ray casting over a vertex memory, or circle distance test
// a load is written to the vertex memory when taken, busy stays low
// a polygon query reads one vertex from the memory port per cycle, n the vertex count in
// use, then passes three pipeline stages before the done strobe
// a circle query passes the same stages; the next start is taken in the cycle of the done strobe
// reset clears configuration to its defaults; vertex memory contents are not reset
`include "point_in_shape_test_defines.svh"

module point_in_shape_test
  import pis_pkg::*;
#(
  parameter int MAX_VERTICES = 32,
  parameter int COORD_BITS   = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start,
  output logic                   busy,
  input  logic                   op_i,
  input  logic [INDEX_W-1:0]     vertex_index_i,
  input  logic [COORD_W-1:0]     vertex_x_i,
  input  logic [COORD_W-1:0]     vertex_y_i,
  input  logic [COORD_W-1:0]     point_x_i,
  input  logic [COORD_W-1:0]     point_y_i,
  output logic                   done_o,
  output logic                   inside_res_o,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i
);

  localparam int AW   = $clog2(MAX_VERTICES);
  localparam int CW   = COORD_BITS;
  localparam int OW   = CW + 2;
  localparam int PW   = 2 * OW;
  localparam int R2W  = 2 * RADIUS_W;
  localparam int CMPW = (PW + 1 > R2W + 1) ? PW + 1 : R2W + 1;
  localparam int CAP  = (MAX_VERTICES < 63) ? MAX_VERTICES : 63;

  // configuration
  logic                shape_mode_q;
  logic [COUNT_W-1:0]  vertex_count_q;
  logic [COORD_W-1:0]  center_x_q, center_y_q;
  logic [RADIUS_W-1:0] circle_radius_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shape_mode_q    <= MODE_POLYGON;
      vertex_count_q  <= COUNT_RESET;
      center_x_q      <= '0;
      center_y_q      <= '0;
      circle_radius_q <= RADIUS_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_SHAPE_MODE:    shape_mode_q    <= cfg_data_i[0];
        CFG_VERTEX_COUNT:  vertex_count_q  <= cfg_data_i[COUNT_W-1:0];
        CFG_CENTER_X:      center_x_q      <= cfg_data_i;
        CFG_CENTER_Y:      center_y_q      <= cfg_data_i;
        CFG_CIRCLE_RADIUS: circle_radius_q <= cfg_data_i[RADIUS_W-1:0];
        default: ;
      endcase
    end
  end

  logic [COUNT_W-1:0] n_eff;
  assign n_eff = (int'(vertex_count_q) > CAP) ? COUNT_W'(CAP) : vertex_count_q;

  // handshake
  state_e state_q, state_d;
  logic   accept, load_we, query_go;

  assign busy     = (state_q != ST_IDLE);
  assign accept   = start && !busy;
  assign load_we  = accept && (op_e'(op_i) == OP_LOAD)
                    && (int'(vertex_index_i) < MAX_VERTICES);
  assign query_go = accept && (op_e'(op_i) == OP_QUERY);

  logic signed [CW-1:0] px_q, py_q;
  always_ff @(posedge clk_i) begin
    if (query_go) begin
      px_q <= point_x_i[CW-1:0];
      py_q <= point_y_i[CW-1:0];
    end
  end

  // vertex memories, one read port each with registered data
  logic [CW-1:0] mem_x [MAX_VERTICES];
  logic [CW-1:0] mem_y [MAX_VERTICES];
  logic [CW-1:0] rd_x_q, rd_y_q;
  logic          rd_en;
  logic [AW-1:0] rd_addr;

  always_ff @(posedge clk_i) begin
    if (load_we) begin
      mem_x[AW'(vertex_index_i)] <= vertex_x_i[CW-1:0];
      mem_y[AW'(vertex_index_i)] <= vertex_y_i[CW-1:0];
    end
    if (rd_en) begin
      rd_x_q <= mem_x[rd_addr];
      rd_y_q <= mem_y[rd_addr];
    end
  end

  // slot sequencer
  logic [COUNT_W-1:0] slot_q, slot_d;
  slot_t              issue;
  slot_t              s1_q, s2_q, s3_q;
  logic               par_q, par_d;
  logic               done_d, inside_d, inside_q, done_q, hit;

  assign rd_addr = AW'(slot_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      slot_q  <= '0;
      par_q   <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      slot_q  <= slot_d;
      par_q   <= par_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (done_d) inside_q <= inside_d;
  end

  assign done_o       = done_q;
  assign inside_res_o = inside_q;

  always_comb begin
    state_d  = state_q;
    slot_d   = slot_q;
    issue    = '0;
    rd_en    = 1'b0;
    par_d    = par_q;
    done_d   = 1'b0;
    inside_d = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (query_go) begin
          state_d = ST_RUN;
          slot_d  = '0;
          par_d   = 1'b0;
        end
      end
      ST_RUN: begin
        issue.valid = 1'b1;
        if (shape_mode_q == MODE_CIRCLE) begin
          issue.circle = 1'b1;
          issue.last   = 1'b1;
        end else begin
          rd_en        = (slot_q < n_eff);
          issue.first  = (slot_q == '0) && (n_eff != '0);
          issue.edge_v = (slot_q != '0);
          issue.close  = (slot_q == n_eff) && (n_eff != '0);
          issue.last   = (slot_q == n_eff);
        end
        if (issue.last) begin
          state_d = ST_DRAIN;
        end else begin
          slot_d = COUNT_W'(slot_q + 1'b1);
        end
      end
      ST_DRAIN: begin
        if (s3_q.valid && s3_q.last) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    // the crossing count runs at the compare stage
    if (s3_q.valid) begin
      par_d = par_q ^ hit;
      if (s3_q.last) begin
        done_d   = 1'b1;
        inside_d = s3_q.circle ? hit : (par_q ^ hit);
      end
    end
  end

  // stage 1: form edge operands from the memory data
  logic [CW-1:0]        v0x_q, v0y_q, prevx_q, prevy_q;
  logic signed [CW-1:0] ax, ay, bx, by, cx, cy;
  logic signed [OW-1:0] dd, m0a, m0b, m1a, m1b;
  logic                 strad;

  always_ff @(posedge clk_i) begin
    if (s1_q.valid && s1_q.first) begin
      v0x_q <= rd_x_q;
      v0y_q <= rd_y_q;
    end
    if (s1_q.valid && (s1_q.first || (s1_q.edge_v && !s1_q.close))) begin
      prevx_q <= rd_x_q;
      prevy_q <= rd_y_q;
    end
  end

  always_comb begin
    ax = prevx_q;
    ay = prevy_q;
    bx = s1_q.close ? v0x_q : rd_x_q;
    by = s1_q.close ? v0y_q : rd_y_q;
    cx = center_x_q[CW-1:0];
    cy = center_y_q[CW-1:0];
    strad = (ay > py_q) != (by > py_q);
    dd    = OW'(by) - OW'(ay);
    if (s1_q.circle) begin
      m0a = OW'(px_q) - OW'(cx);
      m0b = m0a;
      m1a = OW'(py_q) - OW'(cy);
      m1b = m1a;
    end else begin
      // (px-ax)*|d| against (bx-ax)*(py-ay)*sign(d)
      m0a = OW'(px_q) - OW'(ax);
      m0b = dd[OW-1] ? -dd : dd;
      m1a = dd[OW-1] ? (OW'(ax) - OW'(bx)) : (OW'(bx) - OW'(ax));
      m1b = OW'(py_q) - OW'(ay);
    end
  end

  // stage 2 and 3 registers
  logic signed [OW-1:0] op0a_q, op0b_q, op1a_q, op1b_q;
  logic                 strad2_q, strad3_q;
  logic signed [PW-1:0] prod0_q, prod1_q;
  logic [R2W-1:0]       r2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q <= '0;
      s2_q <= '0;
      s3_q <= '0;
    end else begin
      s1_q <= issue;
      s2_q <= s1_q;
      s3_q <= s2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    op0a_q   <= m0a;
    op0b_q   <= m0b;
    op1a_q   <= m1a;
    op1b_q   <= m1b;
    strad2_q <= strad;
    prod0_q  <= op0a_q * op0b_q;
    prod1_q  <= op1a_q * op1b_q;
    r2_q     <= R2W'(circle_radius_q) * R2W'(circle_radius_q);
    strad3_q <= strad2_q;
  end

  // compare stage
  logic signed [CMPW-1:0] sq_sum, r2w;
  always_comb begin
    sq_sum = CMPW'(prod0_q) + CMPW'(prod1_q);
    r2w    = CMPW'($signed({1'b0, r2_q}));
    if (s3_q.circle) begin
      hit = (sq_sum < r2w);
    end else begin
      hit = s3_q.edge_v && strad3_q && (prod0_q < prod1_q);
    end
  end

  `PIS_ASSERT_IMP(a_load_idle, load_we, !busy, "vertex write while busy")
  `PIS_ASSERT_NXT(a_query_busy, query_go, busy, "query accepted but block not busy")
  `PIS_ASSERT_NXT(a_last_done, s3_q.valid && s3_q.last, done_o, "last slot gave no result")
  `PIS_ASSERT_IMP(a_done_drain, done_o, $past(state_q) == ST_DRAIN, "result outside drain")
  `PIS_ASSERT_IMP(a_slot_bound, state_q == ST_RUN, slot_q <= n_eff, "slot counter past count")

endmodule

>>> test/tb.sv
`timescale 1ns / 100ps
// self-checking testbench for the point-in-shape test block: directed and random beats
module tb;
  import pis_pkg::*;

  localparam int NUM_SLOTS    = 32;
  localparam int SETTLE       = 48;
  localparam int STALL_LIMIT  = 4000;
  localparam int TARGET_ITEMS = 1000;
  localparam logic [COORD_W-1:0] ONE   = 32'h0001_0000;
  localparam logic [COORD_W-1:0] C_MIN = 32'h8000_0000;
  localparam logic [COORD_W-1:0] C_MAX = 32'h7FFF_FFFF;

  typedef struct {
    op_e                op;
    logic [INDEX_W-1:0] slot;
    logic [COORD_W-1:0] vx;
    logic [COORD_W-1:0] vy;
    logic [COORD_W-1:0] px;
    logic [COORD_W-1:0] py;
  } beat_t;

  typedef struct {
    bit                 hit;
    logic [COORD_W-1:0] px;
    logic [COORD_W-1:0] py;
  } verdict_t;

  class shape_checker;
    shape_mode_e                mode;
    logic [COUNT_W-1:0]         corner_count;
    logic signed [COORD_W-1:0]  cen_x;
    logic signed [COORD_W-1:0]  cen_y;
    logic [RADIUS_W-1:0]        radius;
    logic signed [COORD_W-1:0]  corner_x [NUM_SLOTS];
    logic signed [COORD_W-1:0]  corner_y [NUM_SLOTS];
    verdict_t                   verdicts [$];
    int mismatches, checked, loads, poly_queries, circle_queries;

    function new();
      mode           = MODE_POLYGON;
      corner_count   = COUNT_RESET;
      cen_x          = '0;
      cen_y          = '0;
      radius         = RADIUS_RESET;
      mismatches     = 0;
      checked        = 0;
      loads          = 0;
      poly_queries   = 0;
      circle_queries = 0;
    endfunction

    function void set_reg(cfg_reg_e which, logic [CFG_DATA_W-1:0] data);
      case (which)
        CFG_SHAPE_MODE:    mode = shape_mode_e'(data[0]);
        CFG_VERTEX_COUNT:  corner_count = data[COUNT_W-1:0];
        CFG_CENTER_X:      cen_x = data;
        CFG_CENTER_Y:      cen_y = data;
        CFG_CIRCLE_RADIUS: radius = data[RADIUS_W-1:0];
        default: ;
      endcase
    endfunction

    // horizontal ray to +x; the crossing compare is cross-multiplied, never divided
    function bit ray_parity(longint px, longint py);
      longint ax, ay, bx, by, dy;
      logic signed [127:0] lhs, rhs, t1, t2;
      int n, j, k;
      bit odd;
      n = (corner_count > NUM_SLOTS) ? NUM_SLOTS : int'(corner_count);
      odd = 1'b0;
      for (j = 0; j < n; j++) begin
        k = (j + 1 == n) ? 0 : j + 1;
        ax = corner_x[j];
        ay = corner_y[j];
        bx = corner_x[k];
        by = corner_y[k];
        if ((ay > py) != (by > py)) begin
          dy  = by - ay;
          t1  = px - ax;
          t2  = (dy < 0) ? -dy : dy;
          lhs = t1 * t2;
          t1  = bx - ax;
          t2  = py - ay;
          rhs = t1 * t2;
          if (dy < 0) rhs = -rhs;
          if (lhs < rhs) odd = ~odd;
        end
      end
      return odd;
    endfunction

    function bit in_disc(longint px, longint py);
      logic signed [127:0] dx, dy, r;
      dx = px - longint'(cen_x);
      dy = py - longint'(cen_y);
      r  = radius;
      return (dx * dx + dy * dy) < (r * r);
    endfunction

    function void note_beat(beat_t b);
      verdict_t v;
      longint px, py;
      if (b.op == OP_LOAD) begin
        corner_x[b.slot] = b.vx;
        corner_y[b.slot] = b.vy;
        loads++;
      end else begin
        px = longint'(signed'(b.px));
        py = longint'(signed'(b.py));
        v.px = b.px;
        v.py = b.py;
        if (mode == MODE_CIRCLE) begin
          v.hit = in_disc(px, py);
          circle_queries++;
        end else begin
          v.hit = ray_parity(px, py);
          poly_queries++;
        end
        verdicts = {verdicts, v};
      end
    endfunction

    task report(string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      mismatches++;
    endtask

    task check(logic got);
      verdict_t v;
      if (verdicts.size() == 0) begin
        report($sformatf("inside_res=%0b with no query waiting", got));
      end else begin
        v = verdicts.pop_front();
        checked++;
        if (got !== v.hit)
          report($sformatf("query (%h,%h): inside_res=%0b, predicted %0b",
                           v.px, v.py, got, v.hit));
      end
    endtask

    function int pending();
      return verdicts.size();
    endfunction
  endclass

  logic                   clk_i          = 1'b0;
  logic                   rst_ni         = 1'b0;
  logic                   start          = 1'b0;
  logic                   op_i           = OP_QUERY;
  logic [INDEX_W-1:0]     vertex_index_i = '0;
  logic [COORD_W-1:0]     vertex_x_i     = '0;
  logic [COORD_W-1:0]     vertex_y_i     = '0;
  logic [COORD_W-1:0]     point_x_i      = '0;
  logic [COORD_W-1:0]     point_y_i      = '0;
  logic                   cfg_valid_i    = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index_i    = '0;
  logic [CFG_DATA_W-1:0]  cfg_data_i     = '0;
  logic                   busy;
  logic                   done_o;
  logic                   inside_res_o;
  logic                   cfg_ready_o;

  shape_checker           sb;
  logic [COORD_W-1:0]     shape_x [NUM_SLOTS];
  logic [COORD_W-1:0]     shape_y [NUM_SLOTS];
  bit                     no_gaps = 1'b0;
  int                     cfg_writes = 0;
  int                     stall_cycles = 0;

  point_in_shape_test dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .op_i           (op_i),
    .vertex_index_i (vertex_index_i),
    .vertex_x_i     (vertex_x_i),
    .vertex_y_i     (vertex_y_i),
    .point_x_i      (point_x_i),
    .point_y_i      (point_y_i),
    .done_o         (done_o),
    .inside_res_o   (inside_res_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni && done_o) sb.check(inside_res_o);
  end

  // watchdog: cycles in which no beat moves on any port
  always @(posedge clk_i) begin
    if ((start && !busy) || done_o || (cfg_valid_i && cfg_ready_o)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("watchdog: nothing moved for %0d cycles", STALL_LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic int idle_len();
    int r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // 0 around +-8.0, 1 integer grid, 2 anything, 3 corner values
  function automatic logic [COORD_W-1:0] rand_coord(int scale);
    case (scale)
      0: return $urandom_range(0, 1 << 20) - (1 << 19);
      1: return (int'($urandom_range(0, 8)) - 4) * 65536;
      2: return $urandom();
      default: begin
        case ($urandom_range(0, 4))
          0: return C_MIN;
          1: return C_MAX;
          2: return '0;
          3: return '1;
          default: return 32'd1;
        endcase
      end
    endcase
  endfunction

  function automatic longint rand_span(longint lim);
    logic [63:0] raw;
    raw = {$urandom(), $urandom()};
    return longint'(raw % (2 * lim + 1)) - lim;
  endfunction

  function automatic logic [COUNT_W-1:0] pick_count();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5)  return $urandom_range(0, 2);
    if (r < 75) return $urandom_range(3, 8);
    if (r < 90) return $urandom_range(9, 31);
    if (r < 95) return NUM_SLOTS;
    return $urandom_range(33, 63);
  endfunction

  function automatic logic [RADIUS_W-1:0] pick_radius();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return RADIUS_RESET;
      3, 4, 5, 6: return $urandom_range(1, 1 << 20);
      default: return $urandom();
    endcase
  endfunction

  task automatic send_beat(beat_t b);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      @(negedge clk_i) start <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    start          <= 1'b1;
    op_i           <= b.op;
    vertex_index_i <= b.slot;
    vertex_x_i     <= b.vx;
    vertex_y_i     <= b.vy;
    point_x_i      <= b.px;
    point_y_i      <= b.py;
    do @(posedge clk_i); while (busy);
    sb.note_beat(b);
  endtask

  task automatic send_load(int slot, logic [COORD_W-1:0] x, logic [COORD_W-1:0] y);
    beat_t b;
    b.op   = OP_LOAD;
    b.slot = slot;
    b.vx   = x;
    b.vy   = y;
    b.px   = $urandom();
    b.py   = $urandom();
    shape_x[slot] = x;
    shape_y[slot] = y;
    send_beat(b);
  endtask

  task automatic send_query(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y);
    beat_t b;
    b.op   = OP_QUERY;
    b.slot = $urandom_range(0, NUM_SLOTS - 1);
    b.vx   = $urandom();
    b.vy   = $urandom();
    b.px   = x;
    b.py   = y;
    send_beat(b);
  endtask

  // loads give no result, so let the block settle before touching registers
  task automatic drain();
    @(negedge clk_i) start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e which, logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= which;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_reg(which, data);
    cfg_writes++;
    @(negedge clk_i) cfg_valid_i <= 1'b0;
  endtask

  // bits above each register's width carry random junk
  task automatic apply_setting(shape_mode_e m, logic [COUNT_W-1:0] cnt,
                               logic [COORD_W-1:0] cx, logic [COORD_W-1:0] cy,
                               logic [RADIUS_W-1:0] r);
    logic [31:0] junk;
    junk = $urandom();
    write_reg(CFG_SHAPE_MODE, {junk[31:1], m});
    write_reg(CFG_VERTEX_COUNT, {junk[31:COUNT_W], cnt});
    write_reg(CFG_CENTER_X, cx);
    write_reg(CFG_CENTER_Y, cy);
    write_reg(CFG_CIRCLE_RADIUS, {junk[31], r});
  endtask

  task automatic directed_checks();
    // square from -1.0 to 1.0 around the origin, reset setting: polygon of four corners
    send_load(0, -ONE, -ONE);
    send_load(1, ONE, -ONE);
    send_load(2, ONE, ONE);
    send_load(3, -ONE, ONE);
    send_query('0, '0);
    send_query(ONE, '0);
    send_query(-ONE, '0);
    send_query('0, ONE);
    send_query('0, -ONE);
    send_query(C_MIN, C_MIN);
    send_query(C_MIN, '0);
    send_query(C_MAX, C_MAX);
    // stretch two corners to the ends of the coordinate range
    send_load(2, C_MAX, C_MAX);
    send_load(0, C_MIN, C_MIN);
    send_query('0, '0);
    send_query(C_MAX - 1, C_MAX - 1);
    send_query(C_MIN, C_MAX);
    drain();
    // unit circle: a point on the circumference is outside
    write_reg(CFG_SHAPE_MODE, MODE_CIRCLE);
    send_query(ONE, '0);
    send_query(ONE - 1, '0);
    send_query('0, '0);
    drain();
    write_reg(CFG_CENTER_X, C_MIN);
    write_reg(CFG_CENTER_Y, C_MIN);
    write_reg(CFG_CIRCLE_RADIUS, {1'b0, {RADIUS_W{1'b1}}});
    send_query(C_MAX, C_MAX);
    send_query(C_MIN, C_MIN);
    drain();
    write_reg(CFG_CIRCLE_RADIUS, '0);
    send_query(C_MIN, C_MIN);
    drain();
    // 3-4-5 triangle puts the point exactly on the circle
    write_reg(CFG_CENTER_X, '0);
    write_reg(CFG_CENTER_Y, '0);
    write_reg(CFG_CIRCLE_RADIUS, 5 * ONE);
    send_query(3 * ONE, 4 * ONE);
    send_query(3 * ONE, 4 * ONE - 1);
    drain();
    // polygons with fewer than three corners
    write_reg(CFG_SHAPE_MODE, MODE_POLYGON);
    write_reg(CFG_VERTEX_COUNT, '0);
    send_query('0, '0);
    drain();
    write_reg(CFG_VERTEX_COUNT, 1);
    send_query(C_MIN, C_MIN);
    drain();
    write_reg(CFG_VERTEX_COUNT, 2);
    send_query(C_MIN, '0);
  endtask

  task automatic random_phase();
    shape_mode_e        m;
    logic [COUNT_W-1:0] cnt;
    logic [COORD_W-1:0] cx, cy, px, py;
    logic [RADIUS_W-1:0] r;
    longint             ox, lim;
    int                 n, scale, queries, q, sel, k;
    m       = ($urandom_range(0, 99) < 60) ? MODE_POLYGON : MODE_CIRCLE;
    cnt     = pick_count();
    n       = (cnt > NUM_SLOTS) ? NUM_SLOTS : int'(cnt);
    scale   = $urandom_range(0, 3);
    cx      = rand_coord($urandom_range(0, 3));
    cy      = rand_coord($urandom_range(0, 3));
    r       = pick_radius();
    queries = $urandom_range(15, 40);
    drain();
    no_gaps = ($urandom_range(0, 3) == 0);
    apply_setting(m, cnt, cx, cy, r);
    if (m == MODE_POLYGON) begin
      for (k = 0; k < n; k++) send_load(k, rand_coord(scale), rand_coord(scale));
    end
    for (q = 0; q < queries; q++) begin
      if ($urandom_range(0, 19) == 0)
        send_load($urandom_range(0, NUM_SLOTS - 1), rand_coord(scale), rand_coord(scale));
      if (m == MODE_POLYGON) begin
        sel = $urandom_range(0, 99);
        if (sel < 50 || n == 0) begin
          px = rand_coord(scale);
          py = rand_coord(scale);
        end else if (sel < 80) begin
          // on or next to corner coordinates, where the strict tests bite
          px = shape_x[$urandom_range(0, n - 1)] + 32'(int'($urandom_range(0, 2)) - 1);
          py = shape_y[$urandom_range(0, n - 1)] + 32'(int'($urandom_range(0, 2)) - 1);
        end else if (sel < 90) begin
          px = rand_coord(scale);
          py = shape_y[$urandom_range(0, n - 1)];
        end else begin
          px = rand_coord($urandom_range(2, 3));
          py = rand_coord($urandom_range(2, 3));
        end
      end else begin
        sel = $urandom_range(0, 99);
        if (sel < 45) begin
          lim = longint'(r) + longint'(r) / 4 + 2;
          px  = cx + 32'(rand_span(lim));
          py  = cy + 32'(rand_span(lim));
        end else if (sel < 65) begin
          // on the circle along an axis, or one step either side
          ox = longint'(r) + int'($urandom_range(0, 2)) - 1;
          if ($urandom_range(0, 1)) ox = -ox;
          if ($urandom_range(0, 1)) begin
            px = cx + 32'(ox);
            py = cy;
          end else begin
            px = cx;
            py = cy + 32'(ox);
          end
        end else if (sel < 75) begin
          px = cx;
          py = cy;
        end else begin
          px = rand_coord($urandom_range(2, 3));
          py = rand_coord($urandom_range(2, 3));
        end
      end
      send_query(px, py);
    end
  endtask

  initial begin
    sb = new();
    repeat (10) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;
    directed_checks();
    while (sb.loads + sb.poly_queries + sb.circle_queries < TARGET_ITEMS) random_phase();
    drain();
    $display("covered %0d vertex loads, %0d polygon and %0d circle queries, %0d register writes",
             sb.loads, sb.poly_queries, sb.circle_queries, cfg_writes);
    $display("checked %0d results, %0d mismatches", sb.checked, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+rtl/core
rtl/core/pis_pkg.sv
rtl/core/point_in_shape_test.sv
test/tb.sv
